FILE: rtl/cft_pkg.sv
// cft_pkg: types and constants shared by the csv field tokenizer
// no dependencies
package cft_pkg;

	localparam logic [7:0] BYTE_CR = 8'd13;
	localparam logic [7:0] BYTE_LF = 8'd10;
	localparam logic [7:0] SEP_RESET = 8'd44;
	localparam logic [7:0] QUOTE_RESET = 8'd34;

	typedef enum logic [1:0] {
		EV_DATA      = 2'd0,
		EV_FIELD_END = 2'd1,
		EV_ROW_END   = 2'd2,
		EV_ERROR     = 2'd3
	} event_kind_t;

	typedef enum logic [0:0] {
		REG_SEPARATOR  = 1'b0,
		REG_QUOTE_CHAR = 1'b1
	} cfg_reg_t;

	typedef enum logic [6:0] {
		MODE_START  = 7'b0000001,
		MODE_SKIP   = 7'b0000010,
		MODE_Q1     = 7'b0000100,
		MODE_PLAIN  = 7'b0001000,
		MODE_QUOTED = 7'b0010000,
		MODE_QQ     = 7'b0100000,
		MODE_ERR    = 7'b1000000
	} parse_mode_t;

	typedef struct packed {
		parse_mode_t mode;
		logic        row_has_fields;
		logic        field_has_bytes;
	} tok_state_t;

	typedef struct packed {
		logic        valid;
		event_kind_t kind;
		logic [7:0]  data;
	} tok_event_t;

endpackage

FILE: rtl/cft_step.sv
// cft_step: next-state and event logic for one input beat
// depends on cft_pkg
module cft_step (
	input  cft_pkg::tok_state_t cur,
	input  logic [7:0]          separator,
	input  logic [7:0]          quote_char,
	input  logic                req_type,
	input  logic [7:0]          data_byte,
	output cft_pkg::tok_state_t nxt,
	output cft_pkg::tok_event_t ev
);
	import cft_pkg::*;

	logic nl;
	logic is_q;
	logic is_sep;
	logic row_end;
	logic field_end;
	logic data_out;
	logic err_out;

	assign nl = (data_byte == BYTE_CR) || (data_byte == BYTE_LF);
	assign is_q = (data_byte == quote_char);
	assign is_sep = (data_byte == separator);

	always_comb begin
		row_end = 1'b0;
		field_end = 1'b0;
		data_out = 1'b0;
		err_out = 1'b0;
		nxt = cur;
		if (req_type) begin
			if (cur.mode == MODE_QQ) begin
				row_end = 1'b1;
			end else if (cur.mode != MODE_ERR &&
					(cur.row_has_fields || cur.field_has_bytes)) begin
				row_end = 1'b1;
			end
			nxt.mode = MODE_START;
			nxt.row_has_fields = 1'b0;
			nxt.field_has_bytes = 1'b0;
		end else begin
			unique case (cur.mode)
				MODE_START, MODE_SKIP: begin
					if (nl) begin
						row_end = (cur.mode == MODE_START);
					end else if (is_q) begin
						nxt.mode = MODE_Q1;
					end else if (is_sep) begin
						field_end = 1'b1;
					end else begin
						nxt.mode = MODE_PLAIN;
						data_out = 1'b1;
					end
				end
				MODE_Q1: begin
					if (nl) begin
						row_end = 1'b1;
					end else if (is_q) begin
						nxt.mode = MODE_START;
					end else begin
						nxt.mode = MODE_QUOTED;
						data_out = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if (nl) begin
						row_end = 1'b1;
					end else if (is_q) begin
						nxt.mode = MODE_QQ;
					end else begin
						data_out = 1'b1;
					end
				end
				MODE_QQ: begin
					if (nl) begin
						row_end = 1'b1;
					end else if (is_q) begin
						nxt.mode = MODE_QUOTED;
						data_out = 1'b1;
					end else if (is_sep) begin
						field_end = 1'b1;
					end else begin
						nxt.mode = MODE_ERR;
						err_out = 1'b1;
					end
				end
				MODE_PLAIN: begin
					if (nl) begin
						row_end = 1'b1;
					end else if (is_sep) begin
						field_end = 1'b1;
					end else begin
						data_out = 1'b1;
					end
				end
				default: begin
					nxt.mode = MODE_ERR;
				end
			endcase
			if (row_end) begin
				nxt.mode = MODE_SKIP;
				nxt.row_has_fields = 1'b0;
				nxt.field_has_bytes = 1'b0;
			end
			if (field_end) begin
				nxt.mode = MODE_START;
				nxt.row_has_fields = 1'b1;
				nxt.field_has_bytes = 1'b0;
			end
			if (data_out) begin
				nxt.field_has_bytes = 1'b1;
			end
		end
	end

	always_comb begin
		ev.valid = row_end || field_end || data_out || err_out;
		ev.data = data_out ? data_byte : 8'd0;
		if (data_out) begin
			ev.kind = EV_DATA;
		end else if (field_end) begin
			ev.kind = EV_FIELD_END;
		end else if (row_end) begin
			ev.kind = EV_ROW_END;
		end else begin
			ev.kind = EV_ERROR;
		end
	end

endmodule

FILE: rtl/csv_field_tokenizer_unit.sv
// csv_field_tokenizer_unit: top level, input register, parse step, result register
// depends on cft_pkg and cft_step
//
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: data_byte, tuser: req_type
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: out_byte, tuser: event_kind
//  cfg       | in  | cfg_we                        | cfg_index, cfg_data
//
// one beat per cycle while m_axis_tready is high; events leave via the result register
// the parse step holds the mode register loop, one update per beat
// reset clears the mode, the flags and both valid flags; registers return to ',' and '"'
// a stalled result holds the input register, which then holds s_axis_tready low
module csv_field_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,   // [0] req_type
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [1:0] event_kind
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import cft_pkg::*;

	logic        sep_sel;
	logic [7:0]  separator_q;
	logic [7:0]  quote_q;
	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	tok_state_t  state_q;
	tok_state_t  state_nxt;
	tok_event_t  ev;
	logic        out_valid_q;
	event_kind_t out_kind_q;
	logic [7:0]  out_byte_q;

	assign sep_sel = (cfg_index == REG_SEPARATOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEP_RESET;
			quote_q <= QUOTE_RESET;
		end else if (cfg_we) begin
			if (sep_sel) begin
				separator_q <= cfg_data;
			end else begin
				quote_q <= cfg_data;
			end
		end
	end

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_type_s1 <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	cft_step u_step (
		.cur        (state_q),
		.separator  (separator_q),
		.quote_char (quote_q),
		.req_type   (req_type_s1),
		.data_byte  (byte_s1),
		.nxt        (state_nxt),
		.ev         (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= MODE_START;
			state_q.row_has_fields <= 1'b0;
			state_q.field_has_bytes <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ev.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev.valid) begin
			out_kind_q <= ev.kind;
			out_byte_q <= ev.data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_byte_q;
	assign m_axis_tuser = out_kind_q;

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.mode))
		else $error("parse mode not one-hot");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != EV_DATA |-> out_byte_q == 8'd0)
		else $error("nonzero byte on control event");

	a_err_mode: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ev.valid && ev.kind == EV_ERROR |=> state_q.mode == MODE_ERR)
		else $error("error event without error mode");

	a_row_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ev.valid && ev.kind == EV_ROW_END |=>
			!state_q.row_has_fields && !state_q.field_has_bytes)
		else $error("row end left field flags set");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a stalled beat");

endmodule

FILE: dv/csv_token_checker.sv
// csv_token_checker: watches the byte and event streams of the csv field tokenizer,
// predicts every event from its own copy of the parse state and compares them in order
// depends on cft_pkg
module csv_token_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,   // [0] req_type
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
	input  logic [1:0] m_axis_tuser,   // [1:0] event_kind
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending
);
	import cft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  data;
	} token_t;

	token_t      expected_tokens[$];
	parse_mode_t mode_q = MODE_START;
	logic        row_fields_q = 1'b0;
	logic        field_bytes_q = 1'b0;
	logic [7:0]  sep_q = SEP_RESET;
	logic [7:0]  quote_q = QUOTE_RESET;
	int          mismatch_total = 0;
	int          pending_q = 0;

	assign fail_count = mismatch_total;
	assign pending = pending_q;

	task automatic push_token(input event_kind_t kind, input logic [7:0] data);
		token_t t;
		t.kind = kind;
		t.data = data;
		expected_tokens = {expected_tokens, t};
	endtask

	task automatic close_row();
		mode_q = MODE_SKIP;
		row_fields_q = 1'b0;
		field_bytes_q = 1'b0;
		push_token(EV_ROW_END, 8'd0);
	endtask

	task automatic close_field();
		mode_q = MODE_START;
		row_fields_q = 1'b1;
		field_bytes_q = 1'b0;
		push_token(EV_FIELD_END, 8'd0);
	endtask

	task automatic keep_byte(input logic [7:0] b);
		field_bytes_q = 1'b1;
		push_token(EV_DATA, b);
	endtask

	task automatic tokenize_beat(input logic eoi, input logic [7:0] b);
		logic nl;
		nl = (b == BYTE_CR) || (b == BYTE_LF);
		if (eoi) begin
			if (mode_q == MODE_QQ)
				close_row();
			else if (mode_q != MODE_ERR && (row_fields_q || field_bytes_q))
				close_row();
			mode_q = MODE_START;
			row_fields_q = 1'b0;
			field_bytes_q = 1'b0;
		end else begin
			case (mode_q)
				MODE_START, MODE_SKIP: begin
					if (nl) begin
						if (mode_q == MODE_START)
							close_row();
					end else if (b == quote_q)
						mode_q = MODE_Q1;
					else if (b == sep_q)
						close_field();
					else begin
						mode_q = MODE_PLAIN;
						keep_byte(b);
					end
				end
				MODE_Q1, MODE_QUOTED: begin
					if (mode_q == MODE_Q1 && !nl && b == quote_q)
						mode_q = MODE_START;
					else if (nl)
						close_row();
					else if (b == quote_q)
						mode_q = MODE_QQ;
					else begin
						mode_q = MODE_QUOTED;
						keep_byte(b);
					end
				end
				MODE_QQ: begin
					if (nl)
						close_row();
					else if (b == quote_q) begin
						mode_q = MODE_QUOTED;
						keep_byte(b);
					end else if (b == sep_q)
						close_field();
					else begin
						mode_q = MODE_ERR;
						push_token(EV_ERROR, 8'd0);
					end
				end
				MODE_PLAIN: begin
					if (nl)
						close_row();
					else if (b == sep_q)
						close_field();
					else
						keep_byte(b);
				end
				default: mode_q = MODE_ERR;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t exp_tok;
		if (!arst_n) begin
			mode_q = MODE_START;
			row_fields_q = 1'b0;
			field_bytes_q = 1'b0;
			sep_q = SEP_RESET;
			quote_q = QUOTE_RESET;
			expected_tokens.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SEPARATOR:  sep_q = cfg_data;
					REG_QUOTE_CHAR: quote_q = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_tokens.size() == 0) begin
					if (mismatch_total < 10)
						$display("%0t: unexpected event kind %0d byte %02h", $realtime,
							m_axis_tuser, m_axis_tdata);
					mismatch_total++;
				end else begin
					exp_tok = expected_tokens.pop_front();
					if (m_axis_tuser !== exp_tok.kind || m_axis_tdata !== exp_tok.data) begin
						if (mismatch_total < 10)
							$display({"%0t: event mismatch, expected kind %0d byte %02h,",
								" got kind %0d byte %02h"}, $realtime, exp_tok.kind,
								exp_tok.data, m_axis_tuser, m_axis_tdata);
						mismatch_total++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				tokenize_beat(s_axis_tuser[0], s_axis_tdata);
		end
		pending_q = expected_tokens.size();
	end

endmodule

FILE: dv/tb.sv
// tb: stimulus for csv_field_tokenizer_unit, directed corner cases then random csv records
// under several separator and quote settings, with random stalls on both streams
// depends on cft_pkg, csv_field_tokenizer_unit and csv_token_checker
module tb;
	import cft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PHASES = 7;
	localparam int BEATS_PER_PHASE = 205;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 80;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	int         mismatch_count;
	int         outstanding;
	int         beats_sent = 0;
	int         gap_pct = 20;
	bit         calm = 1'b0;
	bit         hold_off_req = 1'b0;
	logic [7:0] sep_byte = SEP_RESET;
	logic [7:0] quote_byte = QUOTE_RESET;

	always #5 clk = ~clk;

	csv_field_tokenizer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	csv_token_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (mismatch_count),
		.pending       (outstanding)
	);

	// called at a rising edge, returns at the edge where the beat is taken
	task automatic send_beat(input logic eoi, input logic [7:0] b);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= eoi;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(1'b0, s[i]);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [7:0] sep, input logic [7:0] quote);
		cfg_we <= 1'b1;
		cfg_index <= REG_SEPARATOR;
		cfg_data <= sep;
		@(posedge clk);
		cfg_index <= REG_QUOTE_CHAR;
		cfg_data <= quote;
		@(posedge clk);
		cfg_we <= 1'b0;
		sep_byte = sep;
		quote_byte = quote;
	endtask

	task automatic send_record();
		int fields;
		int len;
		fields = $urandom_range(1, 4);
		for (int f = 0; f < fields; f++) begin
			if (f > 0)
				send_beat(1'b0, sep_byte);
			len = $urandom_range(0, 5);
			case ($urandom_range(0, 2))
				0: for (int k = 0; k < len; k++)
					send_beat(1'b0, 8'($urandom_range(0, 255)));
				1: begin
					send_beat(1'b0, quote_byte);
					for (int k = 0; k < len; k++) begin
						case ($urandom_range(0, 4))
							0: begin
								send_beat(1'b0, quote_byte);
								send_beat(1'b0, quote_byte);
							end
							1: send_beat(1'b0, sep_byte);
							default: send_beat(1'b0, 8'($urandom_range(0, 255)));
						endcase
					end
					send_beat(1'b0, quote_byte);
				end
				default: ;
			endcase
		end
		case ($urandom_range(0, 5))
			0: send_beat(1'b0, BYTE_LF);
			1: send_beat(1'b0, BYTE_CR);
			2: begin
				send_beat(1'b0, BYTE_CR);
				send_beat(1'b0, BYTE_LF);
			end
			3: repeat (3) send_beat(1'b0, BYTE_LF);
			4: send_beat(1'b1, 8'($urandom_range(0, 255)));
			default: ;
		endcase
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 5))
				0: send_beat(1'b0, sep_byte);
				1: send_beat(1'b0, quote_byte);
				2: send_beat(1'b0, BYTE_CR);
				3: send_beat(1'b0, BYTE_LF);
				default: send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// receiver: random ready bursts, one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 9) < 3) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [7:0] sep_plan [NUM_PHASES];
		logic [7:0] quote_plan [NUM_PHASES];
		int         phase_start;
		int         r;
		bit         held;
		bit         paused;
		sep_plan = '{8'd44, 8'd0, 8'd255, BYTE_CR, 8'd59, 8'd44, 8'd0};
		quote_plan = '{8'd34, 8'd255, 8'd0, 8'd34, 8'd59, BYTE_LF, 8'd0};
		sep_plan[NUM_PHASES-1] = 8'($urandom_range(0, 255));
		quote_plan[NUM_PHASES-1] = 8'($urandom_range(0, 255));
		held = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SEPARATOR;
		cfg_data = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// leading newline, skipped newline, extreme bytes
		send_beat(1'b0, BYTE_LF);
		send_beat(1'b0, BYTE_CR);
		send_beat(1'b0, 8'h00);
		send_beat(1'b0, 8'hFF);
		send_beat(1'b0, ",");
		// doubled quote at start, quote in plain field, quoted separator, literal quote
		send_text("\"\"a\",\",\"\"\"");
		send_beat(1'b0, BYTE_LF);
		// junk after closing quote, byte after error, end of input after error
		send_text("\"x\"y");
		send_beat(1'b0, "z");
		send_beat(1'b1, 8'hA5);
		// end of input after closing quote, then on an empty first field
		send_text("\"q\"");
		send_beat(1'b1, 8'h00);
		send_beat(1'b1, 8'hFF);
		// newline right after an opening quote
		send_beat(1'b0, "\"");
		send_beat(1'b0, BYTE_CR);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			apply_config(sep_plan[p], quote_plan[p]);
			calm = (p == NUM_PHASES - 1);
			phase_start = beats_sent;
			while (beats_sent - phase_start < BEATS_PER_PHASE) begin
				if ($urandom_range(0, 15) == 0)
					gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
				if (p == 1 && !held && beats_sent - phase_start > 60) begin
					hold_off_req = 1'b1;
					held = 1'b1;
				end
				if (p == 3 && !paused && beats_sent - phase_start > 100) begin
					settle();
					paused = 1'b1;
				end
				r = $urandom_range(0, 9);
				if (r < 7)
					send_record();
				else if (r < 9)
					send_noise();
				else
					send_beat(1'b1, 8'($urandom_range(0, 255)));
			end
			settle();
		end

		if (mismatch_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/cft_pkg.sv
rtl/cft_step.sv
rtl/csv_field_tokenizer_unit.sv
dv/csv_token_checker.sv
dv/tb.sv
